>>> hw/rtl/ilp_pkg.sv
package ilp_pkg;

	// Width of the result value field on the output channel
	localparam int unsigned RESULT_W = 64;

	// Characters the parser recognises
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_O  = 8'h4F;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_LO_S  = 8'h73;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_ZERO   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_SUFFIX = 4'b1000
	} phase_t;

	// Suffix matcher position; SFX_IDLE also marks a mismatch
	typedef enum logic [9:0] {
		SFX_IDLE   = 10'b00_0000_0001,
		SFX_LEAD   = 10'b00_0000_0010,
		SFX_ONE    = 10'b00_0000_0100,
		SFX_THREE  = 10'b00_0000_1000,
		SFX_SIX    = 10'b00_0001_0000,
		SFX_TWELVE = 10'b00_0010_0000,
		SFX_S      = 10'b00_0100_0000,
		SFX_SI     = 10'b00_1000_0000,
		SFX_SIZ    = 10'b01_0000_0000,
		SFX_DONE   = 10'b10_0000_0000
	} sfx_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	typedef struct packed {
		phase_t phase;
		sfx_t   sfx;
		radix_t radix;
		logic   digit_seen;
		logic   error_seen;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		phase:      PH_START,
		sfx:        SFX_IDLE,
		radix:      RADIX_DEC,
		digit_seen: 1'b0,
		error_seen: 1'b0
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_present;
		logic       end_of_lexeme;
	} char_item_t;

	typedef struct packed {
		logic [RESULT_W-1:0] parsed_value;
		logic                value_ok;
	} value_item_t;

endpackage

>>> hw/rtl/ilp_chan_if.sv
interface ilp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ilp_step.sv
module ilp_step #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic [7:0]            char_code,
	input  logic                  char_present,
	input  ilp_pkg::ctl_t         ctl,
	input  logic [VALUE_BITS-1:0] acc,
	output ilp_pkg::ctl_t         ctl_next,
	output logic [VALUE_BITS-1:0] acc_next
);
	import ilp_pkg::*;

	localparam int unsigned WIDE_W = VALUE_BITS + 4;

	logic              is_dec;
	logic              is_lower_hex;
	logic              is_upper_hex;
	logic              hex_mode;
	logic              char_ok;
	logic [3:0]        digit;
	logic              digit_in_range;
	logic [WIDE_W-1:0] acc_wide;
	logic [WIDE_W-1:0] scaled;
	logic [WIDE_W-1:0] sum;
	logic              overflow;
	logic              digit_good;
	logic              prefix_hit;
	radix_t            prefix_radix;
	sfx_t              sfx_step;

	function automatic sfx_t sfx_advance(sfx_t pos, logic [7:0] c);
		sfx_t n;
		n = SFX_IDLE;
		unique case (pos)
			SFX_LEAD: begin
				if (c == CH_8)
					n = SFX_DONE;
				else if (c == CH_1)
					n = SFX_ONE;
				else if (c == CH_3)
					n = SFX_THREE;
				else if (c == CH_6)
					n = SFX_SIX;
				else if (c == CH_LO_S)
					n = SFX_S;
			end
			SFX_ONE: begin
				if (c == CH_6)
					n = SFX_DONE;
				else if (c == CH_2)
					n = SFX_TWELVE;
			end
			SFX_THREE:  n = (c == CH_2) ? SFX_DONE : SFX_IDLE;
			SFX_SIX:    n = (c == CH_4) ? SFX_DONE : SFX_IDLE;
			SFX_TWELVE: n = (c == CH_8) ? SFX_DONE : SFX_IDLE;
			SFX_S:      n = (c == CH_LO_I) ? SFX_SI : SFX_IDLE;
			SFX_SI:     n = (c == CH_LO_Z) ? SFX_SIZ : SFX_IDLE;
			SFX_SIZ:    n = (c == CH_LO_E) ? SFX_DONE : SFX_IDLE;
			default:    n = SFX_IDLE;
		endcase
		return n;
	endfunction

	// Digit decode and range check against the base
	assign hex_mode     = (ctl.radix == RADIX_HEX);
	assign is_dec       = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_lower_hex = hex_mode && (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
	assign is_upper_hex = hex_mode && (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
	assign char_ok      = is_dec || is_lower_hex || is_upper_hex;

	always_comb begin
		if (is_lower_hex)
			digit = 4'(char_code - CH_LO_A + 8'd10);
		else if (is_upper_hex)
			digit = 4'(char_code - CH_UP_A + 8'd10);
		else
			digit = char_code[3:0];
	end

	always_comb begin
		case (ctl.radix)
			RADIX_OCT: digit_in_range = (digit < 4'd8);
			RADIX_BIN: digit_in_range = (digit < 4'd2);
			default:   digit_in_range = 1'b1;
		endcase
	end

	// Multiply by the base with shifts, add the digit, flag any carry out
	assign acc_wide = WIDE_W'(acc);

	always_comb begin
		case (ctl.radix)
			RADIX_HEX: scaled = acc_wide << 4;
			RADIX_OCT: scaled = acc_wide << 3;
			RADIX_BIN: scaled = acc_wide << 1;
			default:   scaled = (acc_wide << 3) + (acc_wide << 1);
		endcase
	end

	assign sum        = scaled + WIDE_W'(digit);
	assign overflow   = |sum[WIDE_W-1:VALUE_BITS];
	assign digit_good = char_ok && digit_in_range && !overflow;

	always_comb begin
		prefix_hit   = 1'b1;
		prefix_radix = RADIX_DEC;
		if (char_code == CH_LO_X || char_code == CH_UP_X)
			prefix_radix = RADIX_HEX;
		else if (char_code == CH_LO_O || char_code == CH_UP_O)
			prefix_radix = RADIX_OCT;
		else if (char_code == CH_LO_B || char_code == CH_UP_B)
			prefix_radix = RADIX_BIN;
		else
			prefix_hit = 1'b0;
	end

	assign sfx_step = (ctl.sfx == SFX_DONE) ? SFX_IDLE : sfx_advance(ctl.sfx, char_code);

	always_comb begin
		ctl_next = ctl;
		acc_next = acc;
		if (char_present && !ctl.error_seen) begin
			if (ctl.phase == PH_SUFFIX) begin
				if (sfx_step == SFX_IDLE)
					ctl_next.error_seen = 1'b1;
				else
					ctl_next.sfx = sfx_step;
			end else if (char_code == CH_LO_I || char_code == CH_LO_U) begin
				ctl_next.phase = PH_SUFFIX;
				ctl_next.sfx   = SFX_LEAD;
			end else if (ctl.phase == PH_ZERO && prefix_hit) begin
				ctl_next.radix      = prefix_radix;
				ctl_next.digit_seen = 1'b0;
				ctl_next.phase      = PH_DIGITS;
				acc_next            = '0;
			end else if (char_code == CH_UNDER) begin
				ctl_next.phase = PH_DIGITS;
			end else begin
				ctl_next.phase = (ctl.phase == PH_START && char_code == CH_0) ?
					PH_ZERO : PH_DIGITS;
				if (digit_good) begin
					acc_next            = sum[VALUE_BITS-1:0];
					ctl_next.digit_seen = 1'b1;
				end else begin
					ctl_next.error_seen = 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/integer_literal_parser.sv
// Integer literal parser. Feed one character of a lexeme per item on the item
// channel, with end_of_lexeme set on the last one; the lexeme's result then
// appears on the result channel as parsed_value plus value_ok. A leading 0x,
// 0o or 0b (either case) selects base 16, 8 or 2, otherwise the base is 10;
// underscores are skipped and a lower-case i/u suffix (8, 16, 32, 64, 128,
// size) may close the literal. Anything malformed, a missing digit or a value
// above 2^VALUE_BITS-1 gives value_ok low and parsed_value zero. An item with
// neither a character nor the end flag is consumed with no effect. The block
// takes one item every clock unless a finishing item is held: each character
// is decoded and folded into the accumulator (shift-and-add by the base, carry
// check) between the input register and the lexeme state, so the throughput
// is one item per cycle when nothing is held. A lexeme's result is registered
// in the output register as its final item leaves the input register.
// While a result waits on the result channel, characters keep flowing; only a
// second end-of-lexeme item holds in the input register until the first
// result transaction completes. Note that item.ready follows result.ready
// combinationally in that case.
module integer_literal_parser #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ilp_chan_if.sink   item,
	ilp_chan_if.source result
);
	import ilp_pkg::*;

	// Input register
	logic       valid_s1;
	char_item_t item_s1;

	// Lexeme state
	ctl_t                  ctl_q;
	logic [VALUE_BITS-1:0] acc_q;

	// Output register
	logic                out_valid_q;
	logic [RESULT_W-1:0] out_value_q;
	logic                out_ok_q;

	ctl_t                  ctl_next;
	logic [VALUE_BITS-1:0] acc_next;
	logic                  advance;
	logic                  finish;
	logic                  lexeme_ok;

	ilp_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.char_code    (item_s1.char_code),
		.char_present (item_s1.char_present),
		.ctl          (ctl_q),
		.acc          (acc_q),
		.ctl_next     (ctl_next),
		.acc_next     (acc_next)
	);

	// Hold a finishing item only while the previous result is still unclaimed
	assign advance    = valid_s1 && !(item_s1.end_of_lexeme && out_valid_q && !result.ready);
	assign finish     = advance && item_s1.end_of_lexeme;
	assign item.ready = !valid_s1 || advance;

	assign lexeme_ok = !ctl_next.error_seen && (ctl_next.phase != PH_START) &&
		ctl_next.digit_seen && ((ctl_next.phase != PH_SUFFIX) || (ctl_next.sfx == SFX_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= item.payload;
	end

	// Advance the lexeme state; drop it back to the start after each lexeme
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_RESET;
			acc_q <= '0;
		end else if (advance) begin
			if (item_s1.end_of_lexeme) begin
				ctl_q <= CTL_RESET;
				acc_q <= '0;
			end else begin
				ctl_q <= ctl_next;
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_value_q <= lexeme_ok ? RESULT_W'(acc_next) : '0;
			out_ok_q    <= lexeme_ok;
		end
	end

	assign result.valid                = out_valid_q;
	assign result.payload.parsed_value = out_value_q;
	assign result.payload.value_ok     = out_ok_q;

endmodule

>>> hw/rtl/ilp_checker.sv
module ilp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         item_end,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic                         value_ok,
	input logic [ilp_pkg::RESULT_W-1:0] parsed_value
);
	import ilp_pkg::*;

	// Hold a result until its transaction completes
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before its transaction completed");

	// A rejected lexeme reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !value_ok |-> parsed_value == '0)
		else $error("invalid lexeme with non-zero value");

	// A fresh result follows a final item taken earlier, through the input and output registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && item_end, 2))
		else $error("result without a finishing item");

	// With the output empty the input never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled while the output register is empty");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_end     (item.payload.end_of_lexeme),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.value_ok     (result.payload.value_ok),
	.parsed_value (result.payload.parsed_value)
);
